// ===== sv/sws_pkg.sv =====
package sws_pkg;

    localparam int WINDOW_DEPTH_DEF = 3;
    localparam int CHANNELS_DEF     = 4;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int MAX_CH   = 4;
    localparam int TIME_W   = 32;
    localparam int SAMPLE_W = 16;
    localparam int SLOPE_W  = 32;
    localparam int QUO_W    = 32;

    localparam int IN_DATA_W  = TIME_W + MAX_CH * SAMPLE_W;
    localparam int OUT_DATA_W = MAX_CH * SLOPE_W;
    localparam int OUT_USER_W = 3;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_RESET = 1'b1;

    // per-lane step strobes from the sequencer
    typedef struct packed {
        logic clr;
        logic prod;
        logic acc;
        logic mul_init;
        logic mul_step;
        logic num;
        logic div_init;
        logic div_step;
    } t_lane_ctl;

endpackage

// ===== sv/sws_lane.sv =====
module sws_lane #(
    parameter int WINDOW_DEPTH = 3,
    parameter int FRAC_BITS    = 16
) (
    input  logic                                   i_clk,
    input  sws_pkg::t_lane_ctl                     i_ctl,
    input  logic [sws_pkg::TIME_W-1:0]             i_d,
    input  logic signed [sws_pkg::SAMPLE_W-1:0]    i_x,
    input  logic [2*(sws_pkg::TIME_W+$clog2(WINDOW_DEPTH+1))-1:0] i_msh,
    input  logic [2*(sws_pkg::TIME_W+$clog2(WINDOW_DEPTH+1))-1:0] i_den,
    output logic signed [sws_pkg::SLOPE_W-1:0]     o_slope
);
    import sws_pkg::*;

    localparam int LG     = $clog2(WINDOW_DEPTH + 1);
    localparam int SD_W   = TIME_W + LG;
    localparam int DEN_W  = 2 * SD_W;
    localparam int SX_W   = SAMPLE_W + LG;
    localparam int DX_W   = TIME_W + 1 + SAMPLE_W;
    localparam int SDX_W  = DX_W + LG;
    localparam int PROD_W = SD_W + SX_W;
    localparam int NUM_W  = DX_W + 1 + 2 * LG;
    localparam int CMP_W  = DEN_W + QUO_W + 1;

    logic signed [DX_W-1:0]  r_dx;
    logic signed [SAMPLE_W-1:0] r_xq;
    logic signed [SX_W-1:0]  r_sx;
    logic signed [SDX_W-1:0] r_sdx;
    logic [SX_W-1:0]         r_sxmag;
    logic                    r_sxneg;
    logic [PROD_W-1:0]       r_prod;
    logic signed [NUM_W-1:0] r_num;
    logic [NUM_W-1:0]        r_mag;
    logic                    r_neg;
    logic [CMP_W-1:0]        r_rem;
    logic [CMP_W-1:0]        r_dsh;
    logic [QUO_W-1:0]        r_q;

    logic signed [NUM_W-1:0] n_sdx_n;
    logic signed [NUM_W-1:0] n_sprod;
    logic [NUM_W-1:0]        n_mag;

    assign n_sdx_n = NUM_W'($signed({{(NUM_W-SDX_W){r_sdx[SDX_W-1]}}, r_sdx})
                     * $signed(NUM_W'(WINDOW_DEPTH)));
    assign n_sprod = r_sxneg ? -$signed(NUM_W'(r_prod)) : $signed(NUM_W'(r_prod));
    assign n_mag   = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_sx  <= '0;
            r_sdx <= '0;
        end
        if (i_ctl.prod) begin
            r_dx <= $signed({{(DX_W-TIME_W){1'b0}}, i_d})
                    * $signed({{(DX_W-SAMPLE_W){i_x[SAMPLE_W-1]}}, i_x});
            r_xq <= i_x;
        end
        if (i_ctl.acc) begin
            r_sx  <= r_sx + SX_W'(r_xq);
            r_sdx <= r_sdx + SDX_W'(r_dx);
        end
        if (i_ctl.mul_init) begin
            r_sxneg <= r_sx[SX_W-1];
            r_sxmag <= r_sx[SX_W-1] ? SX_W'(-r_sx) : SX_W'(r_sx);
            r_prod  <= '0;
        end
        // shift-add: sd * |sx|, multiplicand shifted by the sequencer
        if (i_ctl.mul_step) begin
            if (r_sxmag[0]) begin
                r_prod <= r_prod + i_msh[PROD_W-1:0];
            end
            r_sxmag <= r_sxmag >> 1;
        end
        if (i_ctl.num) begin
            r_num <= n_sdx_n - n_sprod;
        end
        if (i_ctl.div_init) begin
            r_neg <= r_num[NUM_W-1];
            r_mag <= n_mag;
            r_dsh <= CMP_W'(i_den) << QUO_W;
            r_q   <= '0;
        end
        // rounding: (2*mag*2^F + den) / (2*den), quotient bit 31 flags overflow
        if (i_ctl.div_init) begin
            r_rem <= (CMP_W'(n_mag) << (FRAC_BITS + 1)) + CMP_W'(i_den);
        end else if (i_ctl.div_step) begin
            if (r_rem >= r_dsh) begin
                r_rem <= r_rem - r_dsh;
                r_q   <= {r_q[QUO_W-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[QUO_W-2:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
        end
    end

    always_comb begin
        if (r_q[QUO_W-1]) begin
            o_slope = r_neg ? {1'b1, {(SLOPE_W-1){1'b0}}} : {1'b0, {(SLOPE_W-1){1'b1}}};
        end else begin
            o_slope = r_neg ? -$signed(r_q) : $signed(r_q);
        end
    end

endmodule

// ===== sv/sliding_window_slope_estimator_top.sv =====
// Sliding-window least-squares slope estimator.
// Slave channel: one item per sample; tuser[0] = 1 resets the estimator
// (slot index and full flag cleared, stored entries kept), tuser[0] = 0
// pushes the timestamp and samples in tdata into the ring window.
// Master channel: one item per accepted input item, slopes in tdata and
// the estimate_valid / time_degenerate / first_update_pending flags in tuser.
// A reset command or a push into a window that is not yet full passes
// through S_DONE to the output register without an estimate. A push that
// fills or refills the window runs a full estimate: two read passes over
// the window memory, a serial shift-add multiply and a 32-step restoring
// division in every channel lane. One item is processed at a time; the next
// is accepted once the result sits in the output register, which the
// receiver may drain while the next item works.
// If the receiver stalls, a finished result waits until the output register
// frees. Reset (synchronous, active low) empties the window state and drops
// any held result.
module sliding_window_slope_estimator_top #(
    parameter int WINDOW_DEPTH = sws_pkg::WINDOW_DEPTH_DEF,
    parameter int CHANNELS     = sws_pkg::CHANNELS_DEF,
    parameter int FRAC_BITS    = sws_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // time_stamp[31:0], sample_0[47:32], sample_1, sample_2, sample_3[95:80]
    input  logic [sws_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // command[0]
    input  logic [0:0]                        i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // slope_0[31:0], slope_1, slope_2, slope_3[127:96]
    output logic [sws_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // estimate_valid[0], time_degenerate[1], first_update_pending[2]
    output logic [sws_pkg::OUT_USER_W-1:0]    o_m_tuser
);
    import sws_pkg::*;

    localparam int LG    = $clog2(WINDOW_DEPTH + 1);
    localparam int IW    = $clog2(WINDOW_DEPTH);
    localparam int SD_W  = TIME_W + LG;
    localparam int SDD_W = 2 * TIME_W + LG;
    localparam int DEN_W = 2 * SD_W;
    localparam int MEM_W = TIME_W + CHANNELS * SAMPLE_W;
    localparam int CNT_MAX = (SD_W > QUO_W) ? SD_W : QUO_W;
    localparam int CW    = $clog2(CNT_MAX + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_TMIN, S_ACC, S_MUL_INIT, S_MUL, S_NUM, S_DIV_INIT, S_DIV, S_DONE
    } t_state;

    t_state r_state;

    logic [MEM_W-1:0] mem [WINDOW_DEPTH];
    logic [MEM_W-1:0] r_rd;

    logic [IW-1:0]     r_slot;
    logic              r_full;
    logic              r_await;
    logic              r_calc;
    logic              r_issue;
    logic [IW-1:0]     r_idx;
    logic              r_v1, r_l1, r_v2, r_l2;
    logic [TIME_W-1:0] r_tmin;
    logic [TIME_W-1:0] r_d;
    logic [2*TIME_W-1:0] r_dd;
    logic [SD_W-1:0]   r_sd;
    logic [SDD_W-1:0]  r_sdd;
    logic [DEN_W-1:0]  r_msh;
    logic [SD_W-1:0]   r_mbits;
    logic [DEN_W-1:0]  r_sqr;
    logic [DEN_W-1:0]  r_den;
    logic [CW-1:0]     r_cnt;
    logic              r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;
    logic [OUT_USER_W-1:0] r_ouser;

    logic              n_accept;
    logic              n_push;
    logic              n_fills;
    logic [TIME_W-1:0] n_d;
    logic              n_degen;
    logic              n_out_free;
    t_lane_ctl         n_ctl;
    logic [OUT_DATA_W-1:0] n_odata;
    logic signed [SLOPE_W-1:0] w_slope [CHANNELS];

    assign o_s_tready = (r_state == S_IDLE);
    assign n_accept   = i_s_tvalid && o_s_tready;
    assign n_push     = (i_s_tuser[0] == CMD_PUSH);
    assign n_fills    = r_full || (r_slot == IW'(WINDOW_DEPTH - 1));
    assign n_d        = r_rd[TIME_W-1:0] - r_tmin;
    assign n_degen    = r_calc && (r_den == '0);
    assign n_out_free = !r_ovalid || i_m_tready;

    always_comb begin
        n_ctl          = '0;
        n_ctl.clr      = (r_state == S_TMIN) && r_l1;
        n_ctl.prod     = (r_state == S_ACC) && r_v1;
        n_ctl.acc      = (r_state == S_ACC) && r_v2;
        n_ctl.mul_init = (r_state == S_MUL_INIT);
        n_ctl.mul_step = (r_state == S_MUL);
        n_ctl.num      = (r_state == S_NUM);
        n_ctl.div_init = (r_state == S_DIV_INIT);
        n_ctl.div_step = (r_state == S_DIV);
    end

    // window memory: write on push, one registered read port for the scans
    always_ff @(posedge i_clk) begin
        if (n_accept && n_push) begin
            mem[r_slot] <= i_s_tdata[MEM_W-1:0];
        end
        if (r_issue) begin
            r_rd <= mem[r_idx];
        end
    end

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        sws_lane #(
            .WINDOW_DEPTH (WINDOW_DEPTH),
            .FRAC_BITS    (FRAC_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_ctl   (n_ctl),
            .i_d     (n_d),
            .i_x     ($signed(r_rd[TIME_W+c*SAMPLE_W +: SAMPLE_W])),
            .i_msh   (r_msh),
            .i_den   (r_den),
            .o_slope (w_slope[c])
        );
    end

    // merge: slopes of active lanes, zero when not estimated or degenerate
    for (genvar c = 0; c < MAX_CH; c++) begin : g_merge
        if (c < CHANNELS) begin : g_on
            assign n_odata[c*SLOPE_W +: SLOPE_W] =
                (r_calc && !n_degen) ? w_slope[c] : '0;
        end else begin : g_off
            assign n_odata[c*SLOPE_W +: SLOPE_W] = '0;
        end
    end

    // datapath sums
    always_ff @(posedge i_clk) begin
        if (n_ctl.prod) begin
            r_d  <= n_d;
            r_dd <= {{TIME_W{1'b0}}, n_d} * {{TIME_W{1'b0}}, n_d};
        end
        if (n_ctl.clr) begin
            r_sd  <= '0;
            r_sdd <= '0;
        end else if (n_ctl.acc) begin
            r_sd  <= r_sd + SD_W'(r_d);
            r_sdd <= r_sdd + SDD_W'(r_dd);
        end
        if (n_ctl.mul_init) begin
            r_msh   <= DEN_W'(r_sd);
            r_mbits <= r_sd;
            r_sqr   <= '0;
        end else if (n_ctl.mul_step) begin
            if (r_mbits[0]) begin
                r_sqr <= r_sqr + r_msh;
            end
            r_msh   <= r_msh << 1;
            r_mbits <= r_mbits >> 1;
        end
        if (n_ctl.num) begin
            r_den <= DEN_W'(DEN_W'(r_sdd) * DEN_W'(WINDOW_DEPTH)) - r_sqr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_slot   <= '0;
            r_full   <= 1'b0;
            r_await  <= 1'b1;
            r_calc   <= 1'b0;
            r_issue  <= 1'b0;
            r_idx    <= '0;
            r_v1     <= 1'b0;
            r_l1     <= 1'b0;
            r_v2     <= 1'b0;
            r_l2     <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_v1 <= r_issue;
            r_l1 <= r_issue && (r_idx == IW'(WINDOW_DEPTH - 1));
            r_v2 <= r_v1;
            r_l2 <= r_l1;
            if (r_issue) begin
                if (r_idx == IW'(WINDOW_DEPTH - 1)) begin
                    r_idx   <= '0;
                    r_issue <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (r_ovalid && i_m_tready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        if (!n_push) begin
                            r_slot  <= '0;
                            r_full  <= 1'b0;
                            r_await <= 1'b1;
                            r_calc  <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_await <= 1'b0;
                            r_slot  <= (r_slot == IW'(WINDOW_DEPTH - 1)) ? '0
                                                                          : r_slot + 1'b1;
                            r_full  <= n_fills;
                            r_calc  <= n_fills;
                            if (n_fills) begin
                                r_issue <= 1'b1;
                                r_idx   <= '0;
                                r_tmin  <= '1;
                                r_state <= S_TMIN;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                    end
                end
                S_TMIN: begin
                    if (r_v1 && (r_rd[TIME_W-1:0] < r_tmin)) begin
                        r_tmin <= r_rd[TIME_W-1:0];
                    end
                    // wait out the first pass's delayed strobes before the second
                    if (r_l2) begin
                        r_issue <= 1'b1;
                        r_idx   <= '0;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (r_l2) begin
                        r_state <= S_MUL_INIT;
                    end
                end
                S_MUL_INIT: begin
                    r_cnt   <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(SD_W - 1)) begin
                        r_state <= S_NUM;
                    end
                end
                S_NUM: begin
                    r_state <= S_DIV_INIT;
                end
                S_DIV_INIT: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(QUO_W - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (n_out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= n_odata;
                        r_ouser  <= {r_await, n_degen, r_full};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= IW'(WINDOW_DEPTH - 1))
        else $error("write slot beyond window");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> (o_m_tdata == '0 && o_m_tuser[0]))
        else $error("degenerate result with nonzero slope or no estimate");

    a_first_no_est: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[2]) |-> (!o_m_tuser[0] && o_m_tdata == '0))
        else $error("pending-first result carries an estimate");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_accept |=> !o_s_tready)
        else $error("second item taken while one is in work");

    a_scan_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue |-> (r_state == S_TMIN || r_state == S_ACC))
        else $error("window read outside a scan pass");

endmodule

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sws_pkg::*;

    localparam int DEPTH = WINDOW_DEPTH_DEF;
    localparam int NCH   = CHANNELS_DEF;
    localparam int FRAC  = FRAC_BITS_DEF;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic        cmd;
        logic [31:0] ts;
        logic [15:0] s3;
        logic [15:0] s2;
        logic [15:0] s1;
        logic [15:0] s0;
    } sample_item_t;

    typedef struct packed {
        logic [31:0] sl3;
        logic [31:0] sl2;
        logic [31:0] sl1;
        logic [31:0] sl0;
        logic        pending;
        logic        degen;
        logic        est_valid;
    } slope_item_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [IN_DATA_W-1:0] i_s_tdata = '0;
    logic [0:0] i_s_tuser = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [OUT_USER_W-1:0] o_m_tuser;

    sample_item_t pending_items[$];
    slope_item_t  expected_slopes[$];
    int  errors = 0;
    int  idle_cycles = 0;
    bit  hold_off = 1'b0;
    bit  in_fired = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  stall_phase = 0;

    // estimator state mirror
    logic [31:0] win_ts[DEPTH];
    logic [15:0] win_smp[DEPTH][MAX_CH];
    int  wr_slot = 0;
    bit  full = 1'b0;
    // prediction happens on acceptance; expectations go to the queue in order
    sliding_window_slope_estimator_top u_top (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] round_sat_slope(longint num, logic [127:0] den);
        logic [127:0] mag, top, q;
        mag = (num < 0) ? 128'(-num) : 128'(num);
        top = (mag << (FRAC + 1)) + den;
        q = top / (den << 1);
        if (num < 0) begin
            if (q >= 128'h8000_0000) return 32'h8000_0000;
            return 32'(-q[31:0]);
        end
        if (q > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic slope_item_t estimate_slopes(sample_item_t it);
        slope_item_t r;
        logic [31:0] tmin;
        logic [63:0] sd, dd;
        logic [127:0] sdd, den;
        longint sx, sdx, x, num;
        logic [31:0] sl[MAX_CH];
        r = '0;
        if (it.cmd == CMD_RESET) begin
            wr_slot = 0;
            full = 1'b0;
            r.pending = 1'b1;
            return r;
        end
        win_ts[wr_slot] = it.ts;
        win_smp[wr_slot][0] = it.s0;
        win_smp[wr_slot][1] = it.s1;
        win_smp[wr_slot][2] = it.s2;
        win_smp[wr_slot][3] = it.s3;
        wr_slot++;
        if (wr_slot >= DEPTH) begin
            wr_slot = 0;
            full = 1'b1;
        end
        for (int c = 0; c < MAX_CH; c++) sl[c] = '0;
        if (full) begin
            tmin = win_ts[0];
            for (int i = 1; i < DEPTH; i++) if (win_ts[i] < tmin) tmin = win_ts[i];
            sd = '0;
            sdd = '0;
            for (int i = 0; i < DEPTH; i++) begin
                dd = 64'(win_ts[i] - tmin);
                sd += dd;
                sdd += 128'(dd) * 128'(dd);
            end
            den = sdd * DEPTH - 128'(sd) * 128'(sd);
            if (den == 0) begin
                r.degen = 1'b1;
            end else begin
                for (int c = 0; c < NCH; c++) begin
                    sx = 0;
                    sdx = 0;
                    for (int i = 0; i < DEPTH; i++) begin
                        x = longint'($signed(win_smp[i][c]));
                        sx += x;
                        sdx += longint'(win_ts[i] - tmin) * x;
                    end
                    num = DEPTH * sdx - longint'(sd) * sx;
                    sl[c] = round_sat_slope(num, den);
                end
            end
        end
        r.sl0 = sl[0];
        r.sl1 = sl[1];
        r.sl2 = sl[2];
        r.sl3 = sl[3];
        r.est_valid = full;
        return r;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_s_tvalid || in_fired) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0 && !hold_off) begin
                    sample_item_t it;
                    it = pending_items.pop_front();
                    i_s_tdata <= {it.s3, it.s2, it.s1, it.s0, it.ts};
                    i_s_tuser <= it.cmd;
                    i_s_tvalid <= 1'b1;
                    if (burst_left <= 0) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            stall_phase <= stall_phase + 1;
            case ((stall_phase / 300) % 3)
                0: i_m_tready <= 1'b1;
                1: i_m_tready <= ($urandom_range(0, 3) != 0);
                default: i_m_tready <= (stall_phase % 7) < 2;
            endcase
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_fired <= i_s_tvalid && o_s_tready;
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (i_s_tvalid && o_s_tready) begin
                expected_slopes.insert(expected_slopes.size(),
                    estimate_slopes(sample_item_t'({i_s_tuser[0],
                    i_s_tdata[31:0], i_s_tdata[95:80], i_s_tdata[79:64],
                    i_s_tdata[63:48], i_s_tdata[47:32]})));
            end
            if (o_m_tvalid && i_m_tready) begin
                slope_item_t got, want;
                got = {o_m_tdata, o_m_tuser[2], o_m_tuser[1], o_m_tuser[0]};
                if (expected_slopes.size() == 0) begin
                    $display("%0t unexpected result %h", $time, got);
                    errors++;
                end else begin
                    want = expected_slopes.pop_front();
                    if (got !== want) begin
                        $display("%0t mismatch expected %h actual %h", $time, want, got);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    function automatic sample_item_t mk(logic cmd, logic [31:0] ts, logic [15:0] a,
                                        logic [15:0] b, logic [15:0] c, logic [15:0] d);
        sample_item_t it;
        it.cmd = cmd;
        it.ts = ts;
        it.s0 = a;
        it.s1 = b;
        it.s2 = c;
        it.s3 = d;
        return it;
    endfunction

    function automatic void add_item(sample_item_t it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic logic [15:0] rand_smp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [31:0] t;
        int n;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, equal timestamps, saturation, reset mid-window
        add_item(mk(CMD_PUSH, 0, 16'h7FFF, 16'h8000, 0, 16'hFFFF));
        add_item(mk(CMD_PUSH, 1, 16'h8000, 16'h7FFF, 0, 16'h0001));
        add_item(mk(CMD_PUSH, 2, 16'h7FFF, 16'h8000, 0, 16'hFFFF));
        add_item(mk(CMD_PUSH, 3, 16'h8000, 16'h7FFF, 16'h1234, 0));
        add_item(mk(CMD_RESET, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        for (int i = 0; i < 4; i++)
            add_item(mk(CMD_PUSH, 32'h5555_5555, rand_smp(), rand_smp(),
                        rand_smp(), rand_smp()));
        add_item(mk(CMD_PUSH, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 1, 0));
        add_item(mk(CMD_PUSH, 0, 16'h8000, 16'h7FFF, 0, 1));
        add_item(mk(CMD_PUSH, 32'hFFFF_FFFE, 16'h7FFF, 16'h7FFF, 0, 0));
        add_item(mk(CMD_RESET, 0, 0, 0, 0, 0));
        add_item(mk(CMD_PUSH, 100, 1, 2, 3, 4));
        add_item(mk(CMD_RESET, 0, 0, 0, 0, 0));
        add_item(mk(CMD_PUSH, 10, 0, 0, 0, 0));
        add_item(mk(CMD_PUSH, 10, 16'h7FFF, 0, 0, 0));
        add_item(mk(CMD_PUSH, 11, 16'h8000, 16'h7FFF, 0, 0));
        while (pending_items.size() > 0 || expected_slopes.size() > 0
               || (i_s_tvalid && !in_fired)) @(posedge i_clk);
        // wait for every result before continuing
        hold_off = 1'b1;
        repeat (2) @(posedge i_clk);
        hold_off = 1'b0;
        t = $urandom;
        n = 0;
        while (n < 1550) begin
            case ($urandom_range(0, 19))
                0: add_item(mk(CMD_RESET, $urandom, rand_smp(), rand_smp(),
                               rand_smp(), rand_smp()));
                1: add_item(mk(CMD_PUSH, $urandom, rand_smp(), rand_smp(),
                               rand_smp(), rand_smp()));
                default: begin
                    case ($urandom_range(0, 3))
                        0: t = t;
                        1: t = t + 1;
                        2: t = t + $urandom_range(0, 100);
                        default: t = t + $urandom;
                    endcase
                    add_item(mk(CMD_PUSH, t, rand_smp(), rand_smp(),
                                rand_smp(), rand_smp()));
                end
            endcase
            n++;
            if (n == 700) begin
                while (pending_items.size() > 0 || expected_slopes.size() > 0
                       || (i_s_tvalid && !in_fired))
                    @(posedge i_clk);
                hold_off = 1'b1;
                repeat (20) @(posedge i_clk);
                hold_off = 1'b0;
            end
        end
        while (pending_items.size() > 0 || expected_slopes.size() > 0 || i_s_tvalid)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_slopes.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/sws_pkg.sv
sv/sws_lane.sv
sv/sliding_window_slope_estimator_top.sv
test/tb.sv
